FILE: hdl/srmq_pkg.sv
// Shared constants, item types and helpers for the sparse-table range-maximum block.
package srmq_pkg;

    // Table size and stored value width
    localparam int MAX_ELEMENTS = 512;
    localparam int LEVELS       = 10;
    localparam int VALUE_BITS   = 32;

    // Fixed field widths of the item ports
    localparam int MODE_W      = 2;
    localparam int IN_VALUE_W  = 32;
    localparam int IN_POS_W    = 9;
    localparam int OUT_VALUE_W = 32;
    localparam int STATUS_W    = 2;

    // Derived widths
    localparam int POS_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int LEV_W  = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int DEPTH  = MAX_ELEMENTS * LEVELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WIDE_A = (LEVELS > CNT_W) ? LEVELS : CNT_W;
    localparam int SPAN_W = ((WIDE_A > IN_POS_W) ? WIDE_A : IN_POS_W) + 1;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]            mode;
        logic signed [IN_VALUE_W-1:0] value;
        logic [IN_POS_W-1:0]          left;
        logic [IN_POS_W-1:0]          right;
    } request_t;

    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] maximum;
        logic [STATUS_W-1:0]           status;
    } response_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_APP_STEP,
        ST_Q_A,
        ST_Q_B,
        ST_Q_MAX
    } state_t;

    // Table entry (pos, lev) lives at lev * MAX_ELEMENTS + pos
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LEV_W-1:0] lev,
                                                    input logic [POS_W-1:0] pos);
        return ADDR_W'(ADDR_W'(lev) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(pos));
    endfunction

endpackage

FILE: hdl/srmq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module srmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/sparse_table_range_max.sv
// Sparse-table range-maximum block: sequencer around one level-table RAM.
// Append writes level zero, then runs the chain of level updates (one RAM read and one
// write per level); a query makes two reads on the single RAM read port, then takes the
// larger; clear, rejected and unused items finish straight from idle.
// Throughput: one item at a time; the next item may start in the cycle done is high.
// Reset clears the element count and the sequencer; table contents are not cleared.
module sparse_table_range_max (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  srmq_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output srmq_pkg::response_t response
);

    srmq_pkg::state_t state_reg, state_next;
    logic [srmq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          done_reg, done_next;
    srmq_pkg::response_t           result_reg, result_next;
    logic [srmq_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [srmq_pkg::LEV_W-1:0]    level_reg, level_next;
    logic [srmq_pkg::LEV_W-1:0]    lg_reg, lg_next;
    logic signed [srmq_pkg::VALUE_BITS-1:0] acc_reg, acc_next;
    logic signed [srmq_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic [srmq_pkg::IN_POS_W-1:0] left_reg, left_next;
    logic [srmq_pkg::IN_POS_W-1:0] right_reg, right_next;

    logic                           mem_we;
    logic [srmq_pkg::ADDR_W-1:0]    mem_waddr;
    logic [srmq_pkg::VALUE_BITS-1:0] mem_wdata;
    logic                           mem_re;
    logic [srmq_pkg::ADDR_W-1:0]    mem_raddr;
    logic [srmq_pkg::VALUE_BITS-1:0] mem_rdata;
    logic signed [srmq_pkg::VALUE_BITS-1:0] rd_data;

    logic [srmq_pkg::SPAN_W-1:0]    p1;
    logic [srmq_pkg::SPAN_W-1:0]    lvl_up;
    logic                           more;
    logic [srmq_pkg::POS_W-1:0]     rd_pos;
    logic [srmq_pkg::POS_W-1:0]     wr_pos;
    logic signed [srmq_pkg::VALUE_BITS-1:0] step_max;
    logic [srmq_pkg::SPAN_W-1:0]    q_len;
    logic [srmq_pkg::LEV_W-1:0]     lg_calc;
    logic [srmq_pkg::POS_W-1:0]     q_pos2;
    logic                           bad_range;

    function automatic logic signed [srmq_pkg::VALUE_BITS-1:0] smax(
        input logic signed [srmq_pkg::VALUE_BITS-1:0] a,
        input logic signed [srmq_pkg::VALUE_BITS-1:0] b);
        return (a >= b) ? a : b;
    endfunction

    srmq_ram #(
        .WIDTH (srmq_pkg::VALUE_BITS),
        .DEPTH (srmq_pkg::DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_data  = mem_rdata;
    assign busy     = (state_reg != srmq_pkg::ST_IDLE);
    assign done     = done_reg;
    assign response = result_reg;

    // Append walk: window of the current level ends at the new position
    assign p1       = srmq_pkg::SPAN_W'(pos_reg) + srmq_pkg::SPAN_W'(1);
    assign lvl_up   = srmq_pkg::SPAN_W'(level_reg) + srmq_pkg::SPAN_W'(1);
    assign more     = (lvl_up < srmq_pkg::SPAN_W'(srmq_pkg::LEVELS)) &&
                      (p1 >= (srmq_pkg::SPAN_W'(1) << lvl_up));
    assign rd_pos   = srmq_pkg::POS_W'(p1 - (srmq_pkg::SPAN_W'(1) << lvl_up));
    assign wr_pos   = srmq_pkg::POS_W'(p1 - (srmq_pkg::SPAN_W'(1) << level_reg));
    assign step_max = smax(acc_reg, rd_data);

    // Query range check against the loaded count
    assign bad_range = (request.left > request.right) ||
                       (srmq_pkg::SPAN_W'(request.right) >= srmq_pkg::SPAN_W'(count_reg));

    // Query window level: floor log2 of the range length, capped at the top level
    assign q_len = srmq_pkg::SPAN_W'(right_reg) - srmq_pkg::SPAN_W'(left_reg)
                   + srmq_pkg::SPAN_W'(1);

    always_comb
    begin
        int lg_int;
        lg_int = 0;
        for (int i = 0; i < srmq_pkg::SPAN_W; i++)
        begin
            if (q_len[i])
            begin
                lg_int = i;
            end
        end
        if (lg_int > srmq_pkg::LEVELS - 1)
        begin
            lg_int = srmq_pkg::LEVELS - 1;
        end
        lg_calc = srmq_pkg::LEV_W'(lg_int);
    end

    assign q_pos2 = srmq_pkg::POS_W'(srmq_pkg::SPAN_W'(right_reg) + srmq_pkg::SPAN_W'(1)
                    - (srmq_pkg::SPAN_W'(1) << lg_reg));

    // Sequencer: next state, table accesses and result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        pos_next    = pos_reg;
        level_next  = level_reg;
        lg_next     = lg_reg;
        acc_next    = acc_reg;
        value_next  = value_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = acc_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (state_reg)
            srmq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    value_next          = srmq_pkg::VALUE_BITS'(request.value);
                    left_next           = request.left;
                    right_next          = request.right;
                    pos_next            = srmq_pkg::POS_W'(count_reg);
                    level_next          = '0;
                    result_next.maximum = '0;
                    result_next.status  = srmq_pkg::STATUS_OK;
                    unique case (request.mode)
                        srmq_pkg::MODE_APPEND:
                        begin
                            if (count_reg >= srmq_pkg::CNT_W'(srmq_pkg::MAX_ELEMENTS))
                            begin
                                result_next.status = srmq_pkg::STATUS_FULL;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + srmq_pkg::CNT_W'(1);
                                state_next = srmq_pkg::ST_APPEND;
                            end
                        end
                        srmq_pkg::MODE_QUERY:
                        begin
                            if (bad_range)
                            begin
                                result_next.status = srmq_pkg::STATUS_BAD_RANGE;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                state_next = srmq_pkg::ST_Q_A;
                            end
                        end
                        srmq_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Write level zero, then start the level chain
            srmq_pkg::ST_APPEND:
            begin
                mem_we    = 1'b1;
                mem_waddr = srmq_pkg::slot_addr('0, pos_reg);
                mem_wdata = value_reg;
                acc_next  = value_reg;
                if (more)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = srmq_pkg::slot_addr(level_reg, rd_pos);
                    level_next = srmq_pkg::LEV_W'(lvl_up);
                    state_next = srmq_pkg::ST_APP_STEP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = srmq_pkg::ST_IDLE;
                end
            end

            // Merge the left half with the running maximum and write this level
            srmq_pkg::ST_APP_STEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = srmq_pkg::slot_addr(level_reg, wr_pos);
                mem_wdata = step_max;
                acc_next  = step_max;
                if (more)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = srmq_pkg::slot_addr(level_reg, rd_pos);
                    level_next = srmq_pkg::LEV_W'(lvl_up);
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = srmq_pkg::ST_IDLE;
                end
            end

            // Read the window that starts at left
            srmq_pkg::ST_Q_A:
            begin
                lg_next    = lg_calc;
                mem_re     = 1'b1;
                mem_raddr  = srmq_pkg::slot_addr(lg_calc, srmq_pkg::POS_W'(left_reg));
                state_next = srmq_pkg::ST_Q_B;
            end

            // Read the window that ends at right, hold the first
            srmq_pkg::ST_Q_B:
            begin
                acc_next   = rd_data;
                mem_re     = 1'b1;
                mem_raddr  = srmq_pkg::slot_addr(lg_reg, q_pos2);
                state_next = srmq_pkg::ST_Q_MAX;
            end

            srmq_pkg::ST_Q_MAX:
            begin
                result_next.maximum = srmq_pkg::OUT_VALUE_W'(step_max);
                result_next.status  = srmq_pkg::STATUS_OK;
                done_next           = 1'b1;
                state_next          = srmq_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = srmq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srmq_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        pos_reg    <= pos_next;
        level_reg  <= level_next;
        lg_reg     <= lg_next;
        acc_reg    <= acc_next;
        value_reg  <= value_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
    end

endmodule

FILE: verif/range_max_checker.sv
// Checker for the sparse-table range-maximum block: predicts every result and compares it.
`timescale 1ns / 100ps
module range_max_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  srmq_pkg::request_t  request,
    input  logic                done,
    input  srmq_pkg::response_t response,
    output int                  mismatch_count,
    output int                  responses_due
);
    import srmq_pkg::*;

    // Predicted table: span_max[pos][lev] is the maximum of pos .. pos + 2^lev - 1
    logic signed [VALUE_BITS-1:0] span_max [MAX_ELEMENTS][LEVELS];
    int                           loaded_count = 0;
    response_t                    expected_responses[$];
    int                           errors = 0;
    int                           due = 0;
    int                           results_seen = 0;

    assign mismatch_count = errors;
    assign responses_due  = due;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("%0t: result %0d: %s is %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    // Apply one item to the predicted table and return the result it gives
    function automatic response_t table_step(input request_t item);
        response_t                    res;
        int                           pos;
        int                           lev;
        int                           first;
        int                           l;
        int                           r;
        int                           len;
        int                           lg;
        logic signed [VALUE_BITS-1:0] a;
        logic signed [VALUE_BITS-1:0] b;
        res.maximum = '0;
        res.status  = STATUS_OK;
        l = int'(item.left);
        r = int'(item.right);
        case (item.mode)
            MODE_APPEND:
            begin
                if (loaded_count >= MAX_ELEMENTS)
                    res.status = STATUS_FULL;
                else
                begin
                    // store the value, then fill every window that ends here
                    pos = loaded_count;
                    span_max[pos][0] = VALUE_BITS'(item.value);
                    for (lev = 1; lev < LEVELS; lev++)
                    begin
                        if (pos + 1 < (1 << lev))
                            break;
                        first = pos + 1 - (1 << lev);
                        a = span_max[first][lev - 1];
                        b = span_max[first + (1 << (lev - 1))][lev - 1];
                        span_max[first][lev] = (a > b) ? a : b;
                    end
                    loaded_count = pos + 1;
                end
            end
            MODE_QUERY:
            begin
                if (l > r || r >= loaded_count)
                    res.status = STATUS_BAD_RANGE;
                else
                begin
                    // two overlapping power-of-two windows cover the range
                    len = r - l + 1;
                    lg = 0;
                    while ((len >> (lg + 1)) != 0)
                        lg++;
                    if (lg > LEVELS - 1)
                        lg = LEVELS - 1;
                    a = span_max[l][lg];
                    b = span_max[r + 1 - (1 << lg)][lg];
                    res.maximum = (a > b) ? a : b;
                end
            end
            MODE_CLEAR:
                loaded_count = 0;
            default:
                ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_count = 0;
            expected_responses.delete();
            due <= 0;
        end
        else
        begin
            // compare the result that ends this cycle with the oldest prediction
            if (done)
            begin
                results_seen++;
                if (expected_responses.size() == 0)
                    report_mismatch("result with no item waiting, status",
                                    longint'(response.status), -1);
                else
                begin
                    response_t want;
                    want = expected_responses.pop_front();
                    if (response.maximum !== want.maximum)
                        report_mismatch("maximum", longint'(response.maximum),
                                        longint'(want.maximum));
                    if (response.status !== want.status)
                        report_mismatch("status", longint'(response.status),
                                        longint'(want.status));
                end
            end
            // predict the item accepted at this edge
            if (start && !busy)
                expected_responses.push_back(table_step(request));
            due <= expected_responses.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// Top of the sparse-table range-maximum testbench: clock, reset, item stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
    import srmq_pkg::*;

    localparam int TOTAL_ITEMS = 1450;
    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_CYCLES = 3 * (LEVELS + 1);
    // The block ignores this mode
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    request_t  request = '0;
    logic      busy;
    logic      done;
    response_t response;
    int        mismatch_count;
    int        responses_due;
    int        cycle_count = 0;
    int        loaded = 0;
    int        sent = 0;

    always #5 clk = ~clk;

    sparse_table_range_max DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    range_max_checker table_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .done           (done),
        .response       (response),
        .mismatch_count (mismatch_count),
        .responses_due  (responses_due)
    );

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL sparse_table_range_max");
            $finish;
        end
    end

    function automatic request_t make_item(input logic [MODE_W-1:0] mode,
                                           input logic [IN_VALUE_W-1:0] value,
                                           input int l, input int r);
        request_t item;
        item.mode  = mode;
        item.value = value;
        item.left  = IN_POS_W'(l);
        item.right = IN_POS_W'(r);
        return item;
    endfunction

    // Mix of extremes, small values with ties, and full-range values
    function automatic logic [IN_VALUE_W-1:0] random_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // Hold the item until the block takes it; track the loaded count for shaping
    task automatic send_item(input request_t item);
        request <= item;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (item.mode != MODE_UNUSED)
            sent++;
        if (item.mode == MODE_APPEND && loaded < MAX_ELEMENTS)
            loaded++;
        else if (item.mode == MODE_CLEAR)
            loaded = 0;
    endtask

    // Drop start for a random gap, except in a calm stretch
    task automatic maybe_idle();
        if ((sent < 300 || sent >= 520) && $urandom_range(99) < 20)
        begin
            start   <= 1'b0;
            request <= make_item(MODE_W'($urandom), $urandom,
                                 $urandom_range(511), $urandom_range(511));
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [MODE_W-1:0] mode, input logic [IN_VALUE_W-1:0] value,
                         input int l, input int r);
        send_item(make_item(mode, value, l, r));
        maybe_idle();
    endtask

    // Mostly valid ranges over the loaded values, some noise and off-the-end ranges
    task automatic random_query();
        int l;
        int r;
        int pick;
        pick = (loaded == 0) ? 0 : $urandom_range(9);
        case (pick)
            0:
            begin
                l = $urandom_range(511);
                r = $urandom_range(511);
            end
            1:
            begin
                r = (loaded < MAX_ELEMENTS) ? loaded : MAX_ELEMENTS - 1;
                l = $urandom_range(r);
            end
            2:
            begin
                r = $urandom_range(loaded - 1);
                l = r;
            end
            3:
            begin
                l = 0;
                r = loaded - 1;
            end
            default:
            begin
                r = $urandom_range(loaded - 1);
                l = $urandom_range(r);
            end
        endcase
        issue(MODE_QUERY, $urandom, l, r);
    endtask

    initial
    begin
        int target;
        int steps;
        int pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, value extremes, range edges, ignored mode, clear
        issue(MODE_QUERY, 0, 0, 0);
        issue(MODE_APPEND, 32'h8000_0000, 0, 0);
        issue(MODE_QUERY, 0, 0, 0);
        issue(MODE_APPEND, 32'h7FFF_FFFF, 0, 0);
        issue(MODE_APPEND, 32'h0000_0000, 0, 0);
        issue(MODE_APPEND, 32'hFFFF_FFFF, 0, 0);
        issue(MODE_APPEND, 32'h8000_0000, 0, 0);
        issue(MODE_QUERY, 0, 0, 4);
        issue(MODE_QUERY, 0, 1, 3);
        issue(MODE_QUERY, 0, 2, 4);
        issue(MODE_QUERY, 0, 4, 4);
        issue(MODE_QUERY, 0, 3, 1);
        issue(MODE_QUERY, 0, 0, 5);
        issue(MODE_QUERY, 32'hFFFF_FFFF, 511, 511);
        issue(MODE_UNUSED, 32'hFFFF_FFFF, 511, 511);
        issue(MODE_QUERY, 0, 0, 4);
        issue(MODE_CLEAR, 32'hFFFF_FFFF, 511, 511);
        issue(MODE_QUERY, 0, 0, 0);
        issue(MODE_APPEND, 32'd5, 0, 0);
        issue(MODE_QUERY, 0, 0, 0);

        // Fill the whole table, querying as it grows, then append past the end
        issue(MODE_CLEAR, 0, 0, 0);
        while (loaded < MAX_ELEMENTS)
        begin
            if ($urandom_range(3) == 0)
                random_query();
            else
                issue(MODE_APPEND, random_value(), 0, 0);
        end
        repeat (3) issue(MODE_APPEND, random_value(), 0, 0);
        issue(MODE_QUERY, 0, 0, 511);
        issue(MODE_QUERY, 0, 511, 511);
        issue(MODE_QUERY, 0, 0, 0);
        issue(MODE_QUERY, 0, 256, 511);
        issue(MODE_QUERY, 0, 1, 510);
        repeat (40) random_query();

        // Short data sets, now and then a larger one or a set grown on top of the last
        while (sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(3) != 0 || loaded == MAX_ELEMENTS)
                issue(MODE_CLEAR, $urandom, $urandom_range(511), $urandom_range(511));
            target = ($urandom_range(7) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 40);
            target = (loaded + target > MAX_ELEMENTS) ? MAX_ELEMENTS : loaded + target;
            steps = 2 * (target - loaded) + 4;
            repeat (steps)
            begin
                pick = $urandom_range(19);
                if (pick == 0)
                    issue(MODE_UNUSED, $urandom, $urandom_range(511), $urandom_range(511));
                else if (pick <= 10 && loaded < target)
                    issue(MODE_APPEND, random_value(), $urandom_range(511),
                          $urandom_range(511));
                else
                    random_query();
            end
        end

        // Drain the outstanding results, then let the block settle
        start <= 1'b0;
        @(posedge clk);
        while (responses_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && responses_due == 0)
            $display("PASS sparse_table_range_max");
        else
            $display("FAIL sparse_table_range_max");
        $finish;
    end

endmodule

FILE: sim.f
hdl/srmq_pkg.sv
hdl/srmq_ram.sv
hdl/sparse_table_range_max.sv
verif/range_max_checker.sv
verif/testbench.sv
